[rtl/bskr_pkg.sv]
package bskr_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_WIDTH = 32;

	// Width of the key port and of the top_key result.
	localparam int KEY_PORT_W = 32;
	// Stored key bits: the port carries 32, only the low KEY_WIDTH of them count.
	localparam int KW         = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
	// Entry count holds 0 .. DEPTH.
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CAP_W      = 5;
	localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int OCC_W      = 5;
	localparam int ADDR_W     = 2;
	localparam int DATA_W     = 32;

	localparam logic [CAP_W-1:0]  CAP_RESET    = CAP_W'(16);
	localparam logic [ADDR_W-1:0] REG_CAPACITY = ADDR_W'(0);

	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_PEEK   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// Broadcast to every cell for the word being accepted.
	typedef struct packed {
		logic             push;
		logic             remove;
		logic [CNT_W-1:0] count;
		logic [KW-1:0]    key;
	} cell_ctrl_t;

	// Rippled from the bottom cell upwards.
	typedef struct packed {
		logic          found;
		logic [KW-1:0] top;
	} chain_t;

endpackage

[rtl/bounded_stack_with_key_removal.sv]
// Bounded stack of keys with delete-by-value.
//
// Requests: drive req_type and key with start high; a word is taken at any
// rising edge where start is high and busy is low. busy stays low, so a new
// word may be issued every cycle.
// req_type: push appends key on top (full if capacity reached), remove
// deletes the lowest entry equal to key and closes the gap, peek returns the
// top entry (empty if none).
// Results: one word per request, on status, top_key and occupancy with done
// high for exactly one cycle, the cycle after the request is taken.
// Throughput is one request per cycle, set by the search and shift that
// ripple combinationally through the row of DEPTH cells.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Configuration: APB register capacity_limit at address 0 (reset 16, values
// above DEPTH act as DEPTH). Write it only while no request is in flight.
// Reset: arst_n clears the entry count and the result strobe and sets the
// capacity back to 16.
// The entry store itself is not cleared; only written entries are ever read.
module bounded_stack_with_key_removal
	import bskr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            req_type,
	input  logic [KEY_PORT_W-1:0] key,
	// result channel
	output logic                  done,
	output logic [1:0]            status,
	output logic [KEY_PORT_W-1:0] top_key,
	output logic [OCC_W-1:0]      occupancy,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready
);

	logic [CAP_W-1:0]      cap_q;
	logic [CNT_W-1:0]      count_q;
	logic                  done_q;
	status_t               status_q;
	logic [KEY_PORT_W-1:0] top_key_q;
	logic [OCC_W-1:0]      occupancy_q;

	logic                  accept;
	req_t                  req;
	logic                  room;
	logic                  hit;
	logic                  push_ok;
	logic [CNT_W-1:0]      count_nxt;
	status_t               status_nxt;
	logic [KEY_PORT_W-1:0] top_nxt;
	cell_ctrl_t            ctrl;

	chain_t                chain [DEPTH+1];
	logic [KW-1:0]         cell_key [DEPTH];

	// Configuration port: always ready, one register.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_CAPACITY) ? DATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == REG_CAPACITY)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// Request decode.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign req    = req_t'(req_type);

	// Room to push: below the configured limit and below DEPTH.
	assign room    = (CMP_W'(count_q) < CMP_W'(cap_q)) &&
	                 (CMP_W'(count_q) < CMP_W'(DEPTH));
	assign push_ok = accept && (req == REQ_PUSH) && room;

	assign ctrl.push   = push_ok;
	assign ctrl.remove = accept && (req == REQ_REMOVE);
	assign ctrl.count  = count_q;
	assign ctrl.key    = key[KW-1:0];

	// Row of cells: search and top select ripple upwards from the bottom.
	assign chain[0].found = 1'b0;
	assign chain[0].top   = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bskr_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (CNT_W'(i)),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.up_key    (cell_key[(i + 1 < DEPTH) ? i + 1 : i]),
			.key_out   (cell_key[i])
		);
	end

	assign hit = chain[DEPTH].found;

	// Next count, status and top word.
	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_DONE;
		top_nxt    = '0;
		case (req)
			REQ_PUSH: begin
				if (room) begin
					count_nxt = count_q + CNT_W'(1);
				end else begin
					status_nxt = ST_FULL;
				end
			end
			REQ_REMOVE: begin
				if (hit) begin
					count_nxt = count_q - CNT_W'(1);
				end else begin
					status_nxt = ST_NOT_FOUND;
				end
			end
			REQ_PEEK: begin
				if (count_q == '0) begin
					status_nxt = ST_EMPTY;
				end else begin
					top_nxt = KEY_PORT_W'(chain[DEPTH].top);
				end
			end
			default: begin
				// unused request kind: change nothing, report done
			end
		endcase
	end

	// Hold the count; advance it only on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	// Result word register; payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_nxt;
			top_key_q   <= top_nxt;
			occupancy_q <= OCC_W'(count_nxt);
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign top_key   = top_key_q;
	assign occupancy = occupancy_q;

`ifndef SYNTHESIS
	// The count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(DEPTH))
		else $error("entry count above DEPTH");

	// Every accepted word gives exactly one result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result missing after accepted word");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without accepted word");

	// A push reported full leaves the count alone and reports full.
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req == REQ_PUSH) && !room) |=> ($stable(count_q) && (status_q == ST_FULL)))
		else $error("full push changed the count");

	// Empty on peek only with nothing stored, and with a zero top word.
	a_empty_peek: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q == ST_EMPTY)) |-> ((occupancy_q == '0) && (top_key_q == '0)))
		else $error("empty result with entries or a top word");
`endif

endmodule

[rtl/bskr_cell.sv]
module bskr_cell
	import bskr_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [CNT_W-1:0] idx,
	input  chain_t           chain_in,
	output chain_t           chain_out,
	input  logic [KW-1:0]    up_key,
	output logic [KW-1:0]    key_out
);

	logic [KW-1:0]  key_q;
	logic [CNT_W:0] idx_x;
	logic [CNT_W:0] cnt_x;
	logic           occupied;
	logic           above_occupied;
	logic           is_top;
	logic           match;

	assign idx_x          = (CNT_W + 1)'(idx);
	assign cnt_x          = (CNT_W + 1)'(ctrl.count);
	assign occupied       = idx_x < cnt_x;
	assign above_occupied = (idx_x + (CNT_W + 1)'(1)) < cnt_x;
	assign is_top         = occupied && ((idx_x + (CNT_W + 1)'(1)) == cnt_x);
	assign match          = occupied && (key_q == ctrl.key);

	// Lowest match wins: everything at and above it sees found.
	assign chain_out.found = chain_in.found | match;
	assign chain_out.top   = chain_in.top | (is_top ? key_q : '0);
	assign key_out         = key_q;

	always_ff @(posedge clk) begin
		if (ctrl.push && (idx == ctrl.count)) begin
			key_q <= ctrl.key;
		end else if (ctrl.remove && chain_out.found && above_occupied) begin
			key_q <= up_key;
		end
	end

endmodule
